// ----- rtl/srp_pkg.sv -----
// ============================================================================
// srp_pkg: shared types and constants of the servo percent ramp
// Widths, calibration constants, codes and the controller state type.
// ============================================================================
package srp_pkg;

    localparam int DEG_W  = 8;
    localparam int PCT_W  = 7;
    localparam int PROD_W = 15;
    localparam int CNT_W  = 3;

    localparam int MUL_STEPS = 7;
    localparam int DIV_STEPS = 8;

    localparam logic [DEG_W-1:0] DEG_LIMIT    = 8'd180;
    localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
    localparam logic [DEG_W-1:0] PCT_FULL_DEG = 8'd100;
    localparam logic [DEG_W-1:0] MIN_RESET    = 8'd0;
    localparam logic [DEG_W-1:0] MAX_RESET    = 8'd180;

    typedef enum logic [0:0] {
        FUNC_SET  = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef enum logic [0:0] {
        CFG_MIN = 1'b0,
        CFG_MAX = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic             command_valid;
        logic [DEG_W-1:0] command_degrees;
        logic             moving;
        logic [PCT_W-1:0] current_percent;
    } result_t;

    function automatic logic [DEG_W-1:0] sat_deg(input logic [DEG_W-1:0] v);
        sat_deg = (v > DEG_LIMIT) ? DEG_LIMIT : v;
    endfunction

endpackage

// ----- rtl/srp_if.sv -----
// ============================================================================
// srp_if: request and result channels of the servo percent ramp
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ============================================================================
interface srp_req_if;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [srp_pkg::PCT_W-1:0] target_percent;
    logic [srp_pkg::DEG_W-1:0] servo_angle;

    modport source (output valid, output func, output target_percent,
                    output servo_angle, input ready);
    modport sink   (input valid, input func, input target_percent,
                    input servo_angle, output ready);
endinterface

interface srp_res_if;
    logic                     valid;
    logic                     ready;
    logic                     command_valid;
    logic [srp_pkg::DEG_W-1:0] command_degrees;
    logic                     moving;
    logic [srp_pkg::PCT_W-1:0] current_percent;

    modport source (output valid, output command_valid, output command_degrees,
                    output moving, output current_percent, input ready);
    modport sink   (input valid, input command_valid, input command_degrees,
                    input moving, input current_percent, output ready);
endinterface

// ----- rtl/srp_mul.sv -----
// ============================================================================
// srp_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle into a 16-bit wide accumulator.
// ============================================================================
module srp_mul
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [srp_pkg::DEG_W-1:0]   multiplicand,
    input  logic [srp_pkg::PCT_W-1:0]   multiplier,
    output logic                        done,
    output logic [srp_pkg::PROD_W-1:0]  product
);

    localparam int ACC_W = srp_pkg::DEG_W + 1 + srp_pkg::PCT_W;

    logic [ACC_W-1:0]              acc_reg;
    logic [srp_pkg::DEG_W-1:0]     mcand_reg;
    logic [srp_pkg::CNT_W-1:0]     cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [srp_pkg::DEG_W+1:0]     sum;
    logic [ACC_W-1:0]              acc_next;

    always_comb
    begin
        sum = {1'b0, acc_reg[ACC_W-1:srp_pkg::PCT_W]}
            + (acc_reg[0] ? {2'b00, mcand_reg} : '0);
        acc_next = {sum, acc_reg[srp_pkg::PCT_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == srp_pkg::CNT_W'(srp_pkg::MUL_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= {{(srp_pkg::DEG_W + 1){1'b0}}, multiplier};
            mcand_reg <= multiplicand;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg[srp_pkg::PROD_W-1:0];

endmodule

// ----- rtl/srp_div.sv -----
// ============================================================================
// srp_div: bit-serial restoring divider
// Produces one quotient bit per cycle; the quotient must fit in eight bits.
// ============================================================================
module srp_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [srp_pkg::PROD_W-1:0]  dividend,
    input  logic [srp_pkg::DEG_W-1:0]   divisor,
    output logic                        done,
    output logic [srp_pkg::DEG_W-1:0]   quotient
);

    logic [srp_pkg::DEG_W-1:0] rem_reg;
    logic [srp_pkg::DEG_W-1:0] quo_reg;
    logic [srp_pkg::DEG_W-1:0] dvs_reg;
    logic [srp_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [srp_pkg::DEG_W:0]   trial;
    logic                      fits;
    logic [srp_pkg::DEG_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[srp_pkg::DEG_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? srp_pkg::DEG_W'(trial - {1'b0, dvs_reg})
                        : trial[srp_pkg::DEG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == srp_pkg::CNT_W'(srp_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend[srp_pkg::PROD_W-1:srp_pkg::DEG_W]};
            quo_reg <= dividend[srp_pkg::DEG_W-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[srp_pkg::DEG_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/servo_percent_ramp.sv -----
// A set-target request, or a tick that moves the ramp, gives its result after
// a serial multiply followed by a serial divide; the next request is accepted
// once the result is registered at the output, which waits while one is held.
// A tick that issues no command skips both and goes straight to the done state.
// Reset clears the ramp state and sets the endpoints to 0 and 180 degrees.
// ============================================================================
// servo_percent_ramp: slew-limited servo positioning in percent steps
// Maps between servo angle and percent of the calibrated span and moves the
// ramp position one percent per tick toward the target.
// ============================================================================
module servo_percent_ramp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [srp_pkg::DEG_W-1:0]       cfg_data,
    srp_req_if.sink                         request,
    srp_res_if.source                       result
);

    logic [srp_pkg::DEG_W-1:0] min_reg;
    logic [srp_pkg::DEG_W-1:0] max_reg;

    srp_pkg::state_t           state_reg,   state_next;
    logic [srp_pkg::PCT_W-1:0] pos_reg,     pos_next;
    logic [srp_pkg::PCT_W-1:0] tgt_reg,     tgt_next;
    logic                      active_reg,  active_next;
    logic                      set_op_reg,  set_op_next;
    logic [srp_pkg::DEG_W-1:0] divisor_reg, divisor_next;
    srp_pkg::result_t          pend_reg,    pend_next;
    srp_pkg::result_t          out_reg,     out_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      mul_start;
    logic                      mul_done;
    logic                      div_start;
    logic                      div_done;
    logic [srp_pkg::DEG_W-1:0] mul_a;
    logic [srp_pkg::PCT_W-1:0] mul_b;
    logic [srp_pkg::PROD_W-1:0] product;
    logic [srp_pkg::DEG_W-1:0] quotient;

    logic                      accept;
    logic                      up;
    logic                      equal;
    logic [srp_pkg::DEG_W-1:0] ang;
    logic [srp_pkg::DEG_W-1:0] ang_lo;
    logic [srp_pkg::DEG_W-1:0] ang_cl;
    logic [srp_pkg::DEG_W-1:0] diff;
    logic [srp_pkg::DEG_W-1:0] span;
    logic [srp_pkg::PCT_W-1:0] tgt_sat;
    logic                      step;
    logic [srp_pkg::PCT_W-1:0] new_pos;
    logic [srp_pkg::PCT_W-1:0] set_pos;
    logic [srp_pkg::DEG_W-1:0] cmd_deg;
    logic                      out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= srp_pkg::MIN_RESET;
            max_reg <= srp_pkg::MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (srp_pkg::cfg_idx_t'(cfg_index))
                srp_pkg::CFG_MIN: min_reg <= srp_pkg::sat_deg(cfg_data);
                srp_pkg::CFG_MAX: max_reg <= srp_pkg::sat_deg(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        accept  = request.valid && request.ready;
        up      = max_reg > min_reg;
        equal   = max_reg == min_reg;
        ang     = srp_pkg::sat_deg(request.servo_angle);
        span    = up ? max_reg - min_reg : min_reg - max_reg;
        if (up)
        begin
            ang_lo = (ang < min_reg) ? min_reg : ang;
            ang_cl = (ang_lo > max_reg) ? max_reg : ang_lo;
            diff   = ang_cl - min_reg;
        end
        else
        begin
            ang_lo = (ang > min_reg) ? min_reg : ang;
            ang_cl = (ang_lo < max_reg) ? max_reg : ang_lo;
            diff   = min_reg - ang_cl;
        end
        tgt_sat = (request.target_percent > srp_pkg::PCT_FULL) ? srp_pkg::PCT_FULL
                                                               : request.target_percent;
        step    = active_reg && (pos_reg != tgt_reg);
        new_pos = (pos_reg > tgt_reg) ? pos_reg - 1'b1 : pos_reg + 1'b1;
        set_pos = equal ? srp_pkg::PCT_FULL : quotient[srp_pkg::PCT_W-1:0];
        cmd_deg = up ? min_reg + quotient : min_reg - quotient;
        out_free = !out_valid_reg || result.ready;

        mul_start = accept
                 && (request.func == srp_pkg::FUNC_SET || step);
        mul_a = (request.func == srp_pkg::FUNC_SET) ? diff : span;
        mul_b = (request.func == srp_pkg::FUNC_SET) ? srp_pkg::PCT_FULL : new_pos;
        div_start = (state_reg == srp_pkg::ST_MUL) && mul_done;
    end

    srp_mul u_mul
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (mul_a),
        .multiplier   (mul_b),
        .done         (mul_done),
        .product      (product)
    );

    srp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        tgt_next       = tgt_reg;
        active_next    = active_reg;
        set_op_next    = set_op_reg;
        divisor_next   = divisor_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;

        case (state_reg)
            srp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.func == srp_pkg::FUNC_SET)
                    begin
                        tgt_next     = tgt_sat;
                        set_op_next  = 1'b1;
                        divisor_next = span;
                        state_next   = srp_pkg::ST_MUL;
                    end
                    else if (step)
                    begin
                        pos_next     = new_pos;
                        set_op_next  = 1'b0;
                        divisor_next = srp_pkg::PCT_FULL_DEG;
                        state_next   = srp_pkg::ST_MUL;
                    end
                    else
                    begin
                        active_next = 1'b0;
                        pend_next   = '{1'b0, '0, 1'b0, pos_reg};
                        state_next  = srp_pkg::ST_DONE;
                    end
                end
            end
            srp_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = srp_pkg::ST_DIV;
                end
            end
            srp_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (set_op_reg)
                    begin
                        pos_next    = set_pos;
                        active_next = set_pos != tgt_reg;
                        pend_next   = '{1'b0, '0, set_pos != tgt_reg, set_pos};
                    end
                    else
                    begin
                        pend_next = '{1'b1, cmd_deg, active_reg, pos_reg};
                    end
                    state_next = srp_pkg::ST_DONE;
                end
            end
            srp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = srp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srp_pkg::ST_IDLE;
            pos_reg       <= '0;
            tgt_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            tgt_reg       <= tgt_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_op_reg  <= set_op_next;
        divisor_reg <= divisor_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    assign request.ready          = (state_reg == srp_pkg::ST_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.command_valid   = out_reg.command_valid;
    assign result.command_degrees = out_reg.command_degrees;
    assign result.moving          = out_reg.moving;
    assign result.current_percent = out_reg.current_percent;

endmodule

// ----- rtl/srp_checker.sv -----
// ============================================================================
// srp_checker: port-level checks of the servo percent ramp
// Watches the request and result channels and is bound to the top level.
// ============================================================================
module srp_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        res_command_valid,
    input logic [srp_pkg::DEG_W-1:0]   res_command_degrees,
    input logic                        res_moving,
    input logic [srp_pkg::PCT_W-1:0]   res_current_percent
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before it was taken");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while the previous one is in flight");

    a_cmd_moving: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_command_valid |-> res_moving)
        else $error("command issued while the ramp is not moving");

    a_no_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_command_valid |-> res_command_degrees == '0)
        else $error("angle given without a command");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_current_percent <= srp_pkg::PCT_FULL
                   && res_command_degrees <= srp_pkg::DEG_LIMIT)
        else $error("result out of range");

endmodule

bind servo_percent_ramp srp_checker u_srp_checker
(
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (request.valid),
    .req_ready           (request.ready),
    .res_valid           (result.valid),
    .res_ready           (result.ready),
    .res_command_valid   (result.command_valid),
    .res_command_degrees (result.command_degrees),
    .res_moving          (result.moving),
    .res_current_percent (result.current_percent)
);
